[sv/boundary_tag_heap_allocator_top_macros.svh]
// Assertion macros shared by the allocator's checker.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BTA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, checked outside reset
`define BTA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

[sv/bta_pkg.sv]
// Package for the boundary-tag heap allocator: heap geometry, tag type,
// request and status codes, controller states. No dependencies.
package bta_pkg;

	localparam int HEAP_BYTES = 1024;
	localparam int HEAP_WORDS = HEAP_BYTES / 8;
	localparam int ADDR_W     = $clog2(HEAP_WORDS);
	localparam int SIZE_W     = ADDR_W + 1;

	// Tag word: block size in words and used flag
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              used;
	} tag_t;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_FIT  = 2'd1;
	localparam logic [1:0] STAT_BAD_REL = 2'd2;

	typedef enum logic [2:0] {
		S_INIT_HDR,
		S_INIT_FTR,
		S_IDLE,
		S_WALK,
		S_REL_NEXT,
		S_REL_PREV,
		S_WRITE,
		S_DONE
	} state_t;

endpackage

[sv/boundary_tag_heap_allocator_top.sv]
// Boundary-tag first-fit heap allocator: controller and tag memory.
// Depends on bta_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request per transaction:
//   req_type 0 allocates req_bytes bytes, 1 releases the block whose payload
//   starts at release_offset. Output channel (out_valid/out_stall) returns one
//   status/payload_offset transaction per request, in request order.
//   Tags live in a 128-word synchronous memory (one read port, one write
//   port, registered read). A request walks the block chain from the
//   base, reading one tag per cycle through that single read port and
//   visiting 1 to 64 blocks. An allocation hit then writes 2 or 4 tags;
//   a release reads both neighbour tags and writes 2.
//   A misaligned or zero-offset release is answered without a walk.
//   One request is in work at a time; in_stall is high while it runs.
//   After reset the block writes the header and footer of the single
//   free block before it takes requests.
//   A finished result sits in the output register until taken; a new request
//   may be accepted meanwhile, and its result waits while out_stall is high.
module boundary_tag_heap_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic [10:0] req_bytes,
	input  logic [9:0] release_offset,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [9:0] payload_offset
);
	import bta_pkg::*;

	localparam logic [SIZE_W:0] WORDS_EXT = (SIZE_W+1)'(HEAP_WORDS);

	// Tag memory
	tag_t mem [HEAP_WORDS];
	tag_t rd_tag_q;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	tag_t              wdata;
	logic [ADDR_W-1:0] raddr;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_tag_q <= mem[raddr];
	end

	// Control and datapath registers
	state_t            state_q, state_d;
	logic [SIZE_W-1:0] p_q, p_d;
	logic [SIZE_W-1:0] s_q, s_d;
	logic [9:0]        need_q, need_d;
	logic [ADDR_W-1:0] target_q, target_d;
	logic              rel_q, rel_d;
	logic              split_q, split_d;
	logic              used_q, used_d;
	logic [1:0]        wcnt_q, wcnt_d;
	logic [1:0]        res_stat_q, res_stat_d;
	logic [9:0]        res_off_q, res_off_d;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [9:0]        off_q;
	logic              out_load;

	// Derived values
	logic [SIZE_W:0]   sum_ps;
	logic [SIZE_W:0]   sum_nxt;
	logic [SIZE_W:0]   merged;
	logic              walk_bad;
	logic              fits;
	logic              can_split;
	logic [SIZE_W-1:0] blk;
	logic [SIZE_W-1:0] rest;
	logic [SIZE_W-1:0] need_w;
	logic [11:0]       bytes_up;

	always_comb begin
		sum_ps    = {1'b0, p_q} + {1'b0, rd_tag_q.size};
		sum_nxt   = {1'b0, p_q} + {1'b0, s_q};
		merged    = sum_nxt + {1'b0, rd_tag_q.size};
		walk_bad  = (rd_tag_q.size == '0) || (sum_ps > WORDS_EXT);
		fits      = !rd_tag_q.used && ({{(10-SIZE_W){1'b0}}, rd_tag_q.size} >= need_q);
		can_split = {{(10-SIZE_W){1'b0}}, rd_tag_q.size} >= (need_q + 10'd2);
		need_w    = need_q[SIZE_W-1:0];
		blk       = split_q ? need_w : s_q;
		rest      = s_q - need_w;
		bytes_up  = {1'b0, req_bytes} + 12'd7;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT_HDR;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		p_q        <= p_d;
		s_q        <= s_d;
		need_q     <= need_d;
		target_q   <= target_d;
		rel_q      <= rel_d;
		split_q    <= split_d;
		used_q     <= used_d;
		wcnt_q     <= wcnt_d;
		res_stat_q <= res_stat_d;
		res_off_q  <= res_off_d;
	end

	// Next state, memory control and handshake
	always_comb begin
		state_d    = state_q;
		p_d        = p_q;
		s_d        = s_q;
		need_d     = need_q;
		target_d   = target_q;
		rel_d      = rel_q;
		split_d    = split_q;
		used_d     = used_q;
		wcnt_d     = wcnt_q;
		res_stat_d = res_stat_q;
		res_off_d  = res_off_q;
		we         = 1'b0;
		waddr      = '0;
		wdata      = '0;
		raddr      = '0;
		in_stall   = 1'b1;
		out_load   = 1'b0;

		case (state_q)
			S_INIT_HDR: begin
				we         = 1'b1;
				waddr      = '0;
				wdata.size = SIZE_W'(HEAP_WORDS);
				wdata.used = 1'b0;
				state_d    = S_INIT_FTR;
			end

			S_INIT_FTR: begin
				we         = 1'b1;
				waddr      = ADDR_W'(HEAP_WORDS - 1);
				wdata.size = SIZE_W'(HEAP_WORDS);
				wdata.used = 1'b0;
				state_d    = S_IDLE;
			end

			S_IDLE: begin
				in_stall = 1'b0;
				raddr    = '0;
				if (in_valid) begin
					rel_d    = (req_type == REQ_RELEASE);
					need_d   = {1'b0, bytes_up[11:3]} + 10'd2;
					target_d = release_offset[9:3] - 7'd1;
					p_d      = '0;
					if (req_type == REQ_RELEASE &&
					    (release_offset[2:0] != 3'b000 || release_offset == 10'd0)) begin
						res_stat_d = STAT_BAD_REL;
						res_off_d  = '0;
						state_d    = S_DONE;
					end else begin
						state_d = S_WALK;
					end
				end
			end

			// One block per cycle; next header read issued ahead
			S_WALK: begin
				raddr = sum_ps[ADDR_W-1:0];
				if (!rel_q) begin
					if (walk_bad) begin
						res_stat_d = STAT_NO_FIT;
						res_off_d  = '0;
						state_d    = S_DONE;
					end else if (fits) begin
						s_d     = rd_tag_q.size;
						split_d = can_split;
						used_d  = 1'b1;
						wcnt_d  = '0;
						state_d = S_WRITE;
					end else begin
						p_d = sum_ps[SIZE_W-1:0];
						if (sum_ps >= WORDS_EXT) begin
							res_stat_d = STAT_NO_FIT;
							res_off_d  = '0;
							state_d    = S_DONE;
						end
					end
				end else begin
					if (walk_bad) begin
						res_stat_d = STAT_BAD_REL;
						res_off_d  = '0;
						state_d    = S_DONE;
					end else if (p_q == {1'b0, target_q}) begin
						if (rd_tag_q.used) begin
							s_d     = rd_tag_q.size;
							state_d = S_REL_NEXT;
						end else begin
							res_stat_d = STAT_BAD_REL;
							res_off_d  = '0;
							state_d    = S_DONE;
						end
					end else if (p_q > {1'b0, target_q}) begin
						res_stat_d = STAT_BAD_REL;
						res_off_d  = '0;
						state_d    = S_DONE;
					end else begin
						p_d = sum_ps[SIZE_W-1:0];
						if (sum_ps >= WORDS_EXT) begin
							res_stat_d = STAT_BAD_REL;
							res_off_d  = '0;
							state_d    = S_DONE;
						end
					end
				end
			end

			// Next neighbor header is in rd_tag_q; fetch previous footer
			S_REL_NEXT: begin
				raddr = p_q[ADDR_W-1:0] - ADDR_W'(1);
				if (sum_nxt < WORDS_EXT && !rd_tag_q.used && rd_tag_q.size != '0 &&
				    merged <= WORDS_EXT) begin
					s_d = s_q + rd_tag_q.size;
				end
				state_d = S_REL_PREV;
			end

			// Previous neighbor footer is in rd_tag_q
			S_REL_PREV: begin
				if (p_q != '0 && !rd_tag_q.used && rd_tag_q.size != '0 &&
				    rd_tag_q.size <= p_q) begin
					p_d = p_q - rd_tag_q.size;
					s_d = s_q + rd_tag_q.size;
				end
				split_d = 1'b0;
				used_d  = 1'b0;
				wcnt_d  = '0;
				state_d = S_WRITE;
			end

			// Header/footer writes, then the leftover block on a split
			S_WRITE: begin
				we = 1'b1;
				case (wcnt_q)
					2'd0: begin
						waddr      = p_q[ADDR_W-1:0];
						wdata.size = blk;
						wdata.used = used_q;
					end
					2'd1: begin
						waddr      = p_q[ADDR_W-1:0] + blk[ADDR_W-1:0] - ADDR_W'(1);
						wdata.size = blk;
						wdata.used = used_q;
					end
					2'd2: begin
						waddr      = p_q[ADDR_W-1:0] + need_w[ADDR_W-1:0];
						wdata.size = rest;
						wdata.used = 1'b0;
					end
					default: begin
						waddr      = p_q[ADDR_W-1:0] + s_q[ADDR_W-1:0] - ADDR_W'(1);
						wdata.size = rest;
						wdata.used = 1'b0;
					end
				endcase
				wcnt_d = wcnt_q + 2'd1;
				if ((split_q && wcnt_q == 2'd3) || (!split_q && wcnt_q == 2'd1)) begin
					res_stat_d = STAT_OK;
					if (rel_q) begin
						res_off_d = '0;
					end else begin
						res_off_d = {p_q[ADDR_W-1:0] + ADDR_W'(1), 3'b000};
					end
					state_d = S_DONE;
				end
			end

			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= res_stat_q;
			off_q    <= res_off_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign payload_offset = off_q;

endmodule

[sv/bta_checker.sv]
// Port-level checker for the allocator, bound to the top level.
// Depends on bta_pkg and boundary_tag_heap_allocator_top_macros.svh.
`include "boundary_tag_heap_allocator_top_macros.svh"

module bta_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       req_type,
	input logic [10:0] req_bytes,
	input logic [9:0] release_offset,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [9:0] payload_offset
);
	import bta_pkg::*;

	logic unused_in;
	assign unused_in = in_valid ^ in_stall ^ req_type ^ (^req_bytes) ^ (^release_offset);

	// A stalled result transaction stays put
	`BTA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`BTA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(status) && $stable(payload_offset))

	// Only defined status codes
	`BTA_ASSERT_NOW(a_status_code, out_valid, status <= STAT_BAD_REL)

	// Failures carry no offset; every result offset is word aligned
	`BTA_ASSERT_NOW(a_fail_zero, out_valid && status != STAT_OK, payload_offset == 10'd0)
	`BTA_ASSERT_NOW(a_aligned, out_valid, payload_offset[2:0] == 3'b000)

endmodule

bind boundary_tag_heap_allocator_top bta_checker u_bta_checker (.*);
